[sv/rrpm_pkg.sv]
// ============================================================================
// rrpm_pkg: shared types for the round-robin packet merge
// Word formats of the input and result channels, and the grant status
// passed from the arbiter to the top level.
// ============================================================================
package rrpm_pkg;

    localparam int MASK_BITS = 4;
    localparam int SRC_W     = 2;

    typedef struct packed {
        logic [MASK_BITS-1:0] waiting_mask;
        logic [MASK_BITS-1:0] last_mask;
    } t_in_word;

    typedef struct packed {
        logic [SRC_W-1:0] source_index;
        logic             word_last;
    } t_out_word;

    typedef struct packed {
        logic             hit;
        t_out_word        word;
        logic             locked;
        logic [SRC_W-1:0] cur;
    } t_grant;

endpackage

[sv/rrpm_arb.sv]
// ============================================================================
// rrpm_arb: packet-granular round-robin arbiter
// Holds the lock flag and last granted stream. Scans from the stream after
// the last one served when idle; follows the locked stream otherwise.
// State advances only when i_en is high.
// ============================================================================
module rrpm_arb
    import rrpm_pkg::*;
#(
    parameter int STREAM_COUNT = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_in_word i_word,
    output t_grant   o_grant
);

    localparam int SUM_W = $clog2(STREAM_COUNT + MASK_BITS + 1);

    logic             r_locked;
    logic [SRC_W-1:0] r_cur;
    logic             n_locked;
    logic [SRC_W-1:0] n_cur;
    logic             w_hit;
    logic             w_last;
    logic [SRC_W-1:0] w_sel;

    always_comb begin
        logic [SUM_W-1:0] cand;
        logic             found;
        w_hit  = 1'b0;
        w_last = 1'b0;
        w_sel  = r_cur;
        found  = 1'b0;
        cand   = '0;
        if (r_locked) begin
            w_hit  = i_word.waiting_mask[r_cur];
            w_last = i_word.last_mask[r_cur];
        end else begin
            // highest offset first so the nearest candidate wins
            for (int i = STREAM_COUNT - 1; i >= 0; i--) begin
                cand = SUM_W'(r_cur) + SUM_W'(i) + SUM_W'(1);
                if (cand >= SUM_W'(STREAM_COUNT)) begin
                    cand = cand - SUM_W'(STREAM_COUNT);
                end
                if (cand < SUM_W'(MASK_BITS)) begin
                    if (i_word.waiting_mask[cand[SRC_W-1:0]]) begin
                        found  = 1'b1;
                        w_sel  = cand[SRC_W-1:0];
                        w_last = i_word.last_mask[cand[SRC_W-1:0]];
                    end
                end
            end
            w_hit = found;
        end
    end

    always_comb begin
        n_locked = r_locked;
        n_cur    = r_cur;
        if (i_en && w_hit) begin
            n_cur    = w_sel;
            n_locked = ~w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
            r_cur    <= '0;
        end else begin
            r_locked <= n_locked;
            r_cur    <= n_cur;
        end
    end

    assign o_grant.hit               = w_hit;
    assign o_grant.word.source_index = w_sel;
    assign o_grant.word.word_last    = w_last;
    assign o_grant.locked            = r_locked;
    assign o_grant.cur               = r_cur;

endmodule

[sv/round_robin_packet_merge.sv]
// ============================================================================
// round_robin_packet_merge: merge of packet streams, one packet at a time
// Per-cycle stream status in, one grant word out when a word moves.
// ============================================================================
// Input channel: i_in_valid / o_in_ready carry a status word with, per
// stream, a waiting bit and a last bit. Output channel: o_out_valid /
// i_out_ready carry the granted stream index and its last flag; the data
// itself is muxed outside by that index.
// Path: a status word is registered, arbitrated from the input register and
// the grant is written to the output register when the word advances.
// Throughput: one status word per cycle while the output is not stalled,
// set by the single arbitration stage between the input and output registers.
// A status word that grants nothing produces no output word.
// Reset: arbiter idle, last-served stream 0, so the first scan starts at
// stream 1; both registers empty.
// Stall: while the output word waits, the input register holds one more
// status word; o_in_ready drops only when both are full.
// ============================================================================
module round_robin_packet_merge
    import rrpm_pkg::*;
#(
    parameter int STREAM_COUNT = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      w_adv;
    t_grant    w_grant;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    rrpm_arb #(
        .STREAM_COUNT(STREAM_COUNT)
    ) u_arb (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_word (r_in),
        .o_grant(w_grant)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= w_grant.hit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (w_adv && w_grant.hit) begin
            r_out <= w_grant.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled without full pipeline");

    a_lock_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_grant.hit && w_grant.locked)
        |=> (r_out.source_index == $past(w_grant.cur)))
        else $error("locked grant left its stream");

    a_lock_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_grant.hit && !w_grant.word.word_last) |=> w_grant.locked)
        else $error("mid-packet word did not lock arbiter");

    a_unlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_grant.hit && w_grant.word.word_last) |=> !w_grant.locked)
        else $error("last word did not unlock arbiter");

endmodule
